@@ src/assert_macros.svh @@
// Assertion macros used by the timer queue RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ src/dtq_pkg.sv @@
// Types and constants for the deadline timer queue.
// No dependencies.
`default_nettype none
package dtq_pkg;
  localparam int Capacity = 64;
  localparam int SlotW = $clog2(Capacity);
  localparam int CountW = $clog2(Capacity + 1);

  localparam logic [2:0] ActSchedule = 3'd0;
  localparam logic [2:0] ActTakeId = 3'd1;
  localparam logic [2:0] ActTakeReady = 3'd2;
  localparam logic [2:0] ActTakeNewest = 3'd3;
  localparam logic [2:0] ActPeek = 3'd4;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StNone = 2'd2;
  localparam logic [1:0] StBadId = 2'd3;

  typedef struct packed {
    logic [63:0] deadline;
    logic [31:0] id;
    logic [31:0] tag;
  } slot_t;
endpackage
`default_nettype wire

@@ src/dtq_ram.sv @@
// Single-port-write, single-port-read slot memory with registered read.
// Depends on dtq_pkg.
`default_nettype none
module dtq_ram
  import dtq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [SlotW-1:0]   waddr,
  input  wire slot_t              wdata,
  input  wire logic [SlotW-1:0]   raddr,
  output slot_t                   rdata
);
  slot_t mem [Capacity];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ src/deadline_timer_queue.sv @@
// Deadline timer queue: one item at a time, slot table held in one RAM.
// Schedule and actions that need no search give their result from idle; take
// newest passes through a pick and a done state; a search scans the table,
// then the done state; a removal by id or by readiness then compacts the slots
// behind it. A new input is taken only after the result leaves; output stalls add.
// Synchronous reset: count to zero, id counter to one, limit to 64; slots stay.
`default_nettype none
module deadline_timer_queue
  import dtq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  action,
  input  wire logic [63:0] deadline_ns,
  input  wire logic [63:0] now_ns,
  input  wire logic [31:0] wanted_id,
  input  wire logic [31:0] task_tag,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [31:0]      result_id,
  output logic [63:0]      result_deadline,
  output logic [31:0]      result_tag,
  output logic [6:0]       pending_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  capacity_limit
);
`include "assert_macros.svh"

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_PICK, S_SHIFT, S_DONE} state_t;

  state_t            state;
  logic [2:0]        act;
  logic [63:0]       now_q;
  logic [31:0]       want_q;
  logic [CountW-1:0] count;
  logic [31:0]       next_id;
  logic [6:0]        limit;
  logic [CountW-1:0] ridx;
  logic              rpend;
  logic [SlotW-1:0]  ridx_q;
  logic              found;
  logic [SlotW-1:0]  best;
  slot_t             best_s;
  logic [CountW-1:0] sidx;
  logic              shift_rd;

  logic              we;
  logic [SlotW-1:0]  waddr;
  slot_t             wdata;
  logic [SlotW-1:0]  raddr;
  slot_t             rdata;
  logic [CountW-1:0] eff_limit;
  logic              take;

  dtq_ram u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign in_stall = (state != S_IDLE) || out_valid;
  assign take = in_valid && !in_stall;
  assign cfg_ready = (state == S_IDLE) && !out_valid;
  assign eff_limit = (limit > 7'(Capacity)) ? CountW'(Capacity) : CountW'(limit);
  assign pending_count = 7'(count);

  always_comb begin
    we = 1'b0;
    waddr = SlotW'(count);
    wdata = '{deadline: deadline_ns, id: next_id, tag: task_tag};
    raddr = SlotW'(ridx);
    if (take && action == ActSchedule && count < eff_limit && next_id != '0) begin
      we = 1'b1;
    end else if (state == S_SHIFT) begin
      raddr = SlotW'(sidx);
      we = shift_rd;
      waddr = SlotW'(sidx - 2'd2);
      wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      count <= '0;
      next_id <= 32'd1;
      limit <= 7'd64;
      rpend <= 1'b0;
      shift_rd <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit <= capacity_limit;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            act <= action;
            now_q <= now_ns;
            want_q <= wanted_id;
            status <= StNone;
            result_id <= '0;
            result_deadline <= '0;
            result_tag <= '0;
            found <= 1'b0;
            ridx <= '0;
            rpend <= 1'b0;
            case (action)
              ActSchedule: begin
                out_valid <= 1'b1;
                if (count >= eff_limit || next_id == '0) begin
                  status <= StFull;
                end else begin
                  status <= StOk;
                  result_id <= next_id;
                  next_id <= next_id + 32'd1;
                  count <= count + 1'b1;
                end
              end
              ActTakeId: begin
                if (wanted_id == '0) begin
                  status <= StBadId;
                  out_valid <= 1'b1;
                end else if (count == '0) begin
                  out_valid <= 1'b1;
                end else begin
                  state <= S_SCAN;
                end
              end
              ActTakeReady, ActPeek: begin
                if (count == '0) out_valid <= 1'b1;
                else state <= S_SCAN;
              end
              ActTakeNewest: begin
                if (count == '0) begin
                  out_valid <= 1'b1;
                end else begin
                  ridx <= count - 1'b1;
                  state <= S_PICK;
                end
              end
              default: out_valid <= 1'b1;
            endcase
          end
        end
        S_SCAN: begin
          rpend <= (ridx < count) && !(act == ActTakeId && found);
          ridx_q <= SlotW'(ridx);
          if (ridx < count) ridx <= ridx + 1'b1;
          if (rpend) begin
            if (act == ActTakeId) begin
              if (!found && rdata.id == want_q) begin
                found <= 1'b1;
                best <= ridx_q;
                best_s <= rdata;
              end
            end else if (!found || rdata.deadline < best_s.deadline) begin
              found <= 1'b1;
              best <= ridx_q;
              best_s <= rdata;
            end
          end
          if (!rpend && (ridx >= count || (act == ActTakeId && found))
              && ridx != '0) begin
            state <= S_DONE;
          end
        end
        S_PICK: begin
          state <= S_DONE;
          found <= 1'b1;
          best <= SlotW'(ridx);
          rpend <= 1'b1;
        end
        S_DONE: begin
          if (rpend) begin
            best_s <= rdata;
            rpend <= 1'b0;
          end
          state <= S_IDLE;
          out_valid <= 1'b1;
          if (act == ActTakeNewest) begin
            status <= StOk;
            result_id <= rdata.id;
            result_deadline <= rdata.deadline;
            result_tag <= rdata.tag;
            count <= count - 1'b1;
          end else if (act == ActPeek) begin
            status <= StOk;
            result_deadline <= best_s.deadline;
          end else if (found && (act == ActTakeId || best_s.deadline <= now_q)) begin
            status <= StOk;
            result_id <= best_s.id;
            result_deadline <= best_s.deadline;
            result_tag <= best_s.tag;
            out_valid <= 1'b0;
            sidx <= CountW'(best) + 1'b1;
            shift_rd <= 1'b0;
            ridx <= CountW'(best) + 1'b1;
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (sidx < count) begin
            shift_rd <= 1'b1;
            sidx <= sidx + 1'b1;
          end else begin
            shift_rd <= 1'b0;
            count <= count - 1'b1;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_count_max, count <= CountW'(Capacity), "count above capacity")
  `ASSERT_CLK(a_out_idle, !(out_valid && state != S_IDLE), "result shown while busy")
  `ASSERT_IMPL(a_hold, out_valid && out_stall, out_valid && $stable(status), "result dropped")
endmodule
`default_nettype wire

@@ tb/deadline_timer_queue_test.sv @@
// Self-checking testbench for deadline_timer_queue: directed and random
// actions against an in-bench table model, with random idling on both sides.
// Depends on dtq_pkg and the deadline_timer_queue RTL.
`timescale 1ns / 1ps
module deadline_timer_queue_test;
  import dtq_pkg::*;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] deadline;
    logic [63:0] now;
    logic [31:0] wanted;
    logic [31:0] tag;
  } timer_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] id;
    logic [63:0] deadline;
    logic [31:0] tag;
    logic [6:0]  count;
  } timer_resp_t;

  localparam int IdleLimit = 20000;
  localparam int RandomItems = 1700;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] action = '0;
  logic [63:0] deadline_ns = '0;
  logic [63:0] now_ns = '0;
  logic [31:0] wanted_id = '0;
  logic [31:0] task_tag = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic [31:0] result_id;
  logic [63:0] result_deadline;
  logic [31:0] result_tag;
  logic [6:0] pending_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [6:0] capacity_limit = 7'd64;

  logic [63:0] tbl_deadline [Capacity];
  logic [31:0] tbl_id [Capacity];
  logic [31:0] tbl_tag [Capacity];
  int unsigned tbl_count = 0;
  logic [31:0] id_counter = 32'd1;
  logic [6:0] limit_model = 7'd64;

  timer_resp_t pending_resp [$];
  bit quiet = 1'b0;
  int errors = 0;
  int items_sent = 0;
  int resp_checked = 0;
  int limit_writes = 0;
  int full_seen = 0;
  int ok_takes = 0;

  deadline_timer_queue uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .deadline_ns(deadline_ns), .now_ns(now_ns),
    .wanted_id(wanted_id), .task_tag(task_tag),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .result_id(result_id), .result_deadline(result_deadline),
    .result_tag(result_tag), .pending_count(pending_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .capacity_limit(capacity_limit)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int unsigned earliest_slot();
    int unsigned best;
    best = 0;
    for (int unsigned i = 1; i < tbl_count; i++) begin
      if (tbl_deadline[i] < tbl_deadline[best]) best = i;
    end
    return best;
  endfunction

  function automatic void remove_slot(int unsigned pos);
    for (int unsigned i = pos; i + 1 < tbl_count; i++) begin
      tbl_deadline[i] = tbl_deadline[i + 1];
      tbl_id[i] = tbl_id[i + 1];
      tbl_tag[i] = tbl_tag[i + 1];
    end
    tbl_count--;
  endfunction

  function automatic timer_resp_t apply_timer_action(timer_req_t req);
    timer_resp_t r;
    int unsigned eff;
    int unsigned pos;
    r = '0;
    r.status = StNone;
    eff = (limit_model < Capacity) ? int'(limit_model) : Capacity;
    case (req.action)
      ActSchedule: begin
        if (tbl_count >= eff || id_counter == 0) begin
          r.status = StFull;
        end else begin
          tbl_deadline[tbl_count] = req.deadline;
          tbl_id[tbl_count] = id_counter;
          tbl_tag[tbl_count] = req.tag;
          tbl_count++;
          r.id = id_counter;
          id_counter++;
          r.status = StOk;
        end
      end
      ActTakeId: begin
        if (req.wanted == 0) begin
          r.status = StBadId;
        end else begin
          for (int unsigned i = 0; i < tbl_count; i++) begin
            if (tbl_id[i] == req.wanted) begin
              r.id = tbl_id[i];
              r.deadline = tbl_deadline[i];
              r.tag = tbl_tag[i];
              remove_slot(i);
              r.status = StOk;
              break;
            end
          end
        end
      end
      ActTakeReady: begin
        if (tbl_count > 0) begin
          pos = earliest_slot();
          if (tbl_deadline[pos] <= req.now) begin
            r.id = tbl_id[pos];
            r.deadline = tbl_deadline[pos];
            r.tag = tbl_tag[pos];
            remove_slot(pos);
            r.status = StOk;
          end
        end
      end
      ActTakeNewest: begin
        if (tbl_count > 0) begin
          pos = tbl_count - 1;
          r.id = tbl_id[pos];
          r.deadline = tbl_deadline[pos];
          r.tag = tbl_tag[pos];
          tbl_count--;
          r.status = StOk;
        end
      end
      ActPeek: begin
        if (tbl_count > 0) begin
          r.deadline = tbl_deadline[earliest_slot()];
          r.status = StOk;
        end
      end
      default: ;
    endcase
    r.count = tbl_count[6:0];
    return r;
  endfunction

  task automatic send_item(input logic [2:0] act, input logic [63:0] dl,
                           input logic [63:0] now, input logic [31:0] wanted,
                           input logic [31:0] tag);
    timer_req_t req;
    timer_resp_t r;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    deadline_ns <= dl;
    now_ns <= now;
    wanted_id <= wanted;
    task_tag <= tag;
    do @(posedge clk); while (in_stall);
    req = '{act, dl, now, wanted, tag};
    r = apply_timer_action(req);
    if (r.status == StFull) full_seen++;
    if (r.status == StOk && act != ActSchedule && act != ActPeek) ok_takes++;
    pending_resp.push_back(r);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_resp.size() != 0);
  endtask

  task automatic write_limit(input logic [6:0] value);
    drain_results();
    repeat (150) @(posedge clk);
    cfg_valid <= 1'b1;
    capacity_limit <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_model = value;
    limit_writes++;
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] exp,
                             input logic [63:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
      errors++;
    end
  endtask

  initial begin
    timer_resp_t e;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_resp.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %h", $time,
                   status);
          errors++;
        end else begin
          e = pending_resp.pop_front();
          check_field("status", 64'(e.status), 64'(status));
          check_field("result_id", 64'(e.id), 64'(result_id));
          check_field("result_deadline", e.deadline, result_deadline);
          check_field("result_tag", 64'(e.tag), 64'(result_tag));
          check_field("pending_count", 64'(e.count), 64'(pending_count));
          resp_checked++;
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8) - 1) @(posedge clk);
        @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
          || rst)
        idle = 0;
      else
        idle++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [31:0] pick_id();
    int k;
    k = $urandom_range(0, 9);
    if (tbl_count > 0 && k < 7) return tbl_id[$urandom_range(0, tbl_count - 1)];
    if (k == 7) return 32'd0;
    if (k == 8) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  function automatic logic [63:0] pick_deadline();
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return 64'hFFFF_FFFF_FFFF_FFFF;
      2: return {$urandom(), $urandom()};
      default: return 64'($urandom_range(0, 60));
    endcase
  endfunction

  function automatic logic [63:0] pick_now();
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return 64'hFFFF_FFFF_FFFF_FFFF;
      2: return {$urandom(), $urandom()};
      3: return (tbl_count > 0) ? tbl_deadline[earliest_slot()] : 64'd5;
      default: return 64'($urandom_range(0, 60));
    endcase
  endfunction

  task automatic random_item();
    int k;
    k = $urandom_range(0, 99);
    if (k < 38)
      send_item(ActSchedule, pick_deadline(), 64'($urandom()), $urandom(), $urandom());
    else if (k < 58)
      send_item(ActTakeId, 64'($urandom()), 64'($urandom()), pick_id(), $urandom());
    else if (k < 78)
      send_item(ActTakeReady, 64'($urandom()), pick_now(), $urandom(), $urandom());
    else if (k < 87)
      send_item(ActTakeNewest, 64'($urandom()), 64'($urandom()), $urandom(), $urandom());
    else if (k < 96)
      send_item(ActPeek, 64'($urandom()), 64'($urandom()), $urandom(), $urandom());
    else
      send_item(3'($urandom_range(5, 7)), {$urandom(), $urandom()},
                {$urandom(), $urandom()}, $urandom(), $urandom());
  endtask

  task automatic test_empty_table();
    send_item(ActTakeReady, '0, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
    send_item(ActTakeNewest, '0, '0, '0, '0);
    send_item(ActPeek, '0, '0, '0, '0);
    send_item(ActTakeId, '0, '0, 32'd0, '0);
  endtask

  task automatic test_schedule_and_peek();
    send_item(ActSchedule, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0, 32'hFFFF_FFFF);
    send_item(ActSchedule, 64'd7, '0, '0, 32'h0000_0000);
    send_item(ActSchedule, 64'd7, '0, '0, 32'hA5A5_5A5A);
    send_item(ActSchedule, 64'd0, '0, '0, 32'h5A5A_A5A5);
    send_item(ActPeek, '0, '0, '0, '0);
  endtask

  task automatic test_take_ready();
    send_item(ActTakeReady, '0, 64'd0, '0, '0);
    send_item(ActTakeReady, '0, 64'd6, '0, '0);
    send_item(ActTakeReady, '0, 64'd7, '0, '0);
  endtask

  task automatic test_take_by_id();
    send_item(ActTakeId, '0, '0, 32'd1, '0);
    send_item(ActTakeId, '0, '0, 32'd1, '0);
    send_item(ActTakeId, '0, '0, 32'hFFFF_FFFF, '0);
    send_item(ActTakeNewest, '0, '0, '0, '0);
  endtask

  task automatic test_capacity_limits();
    write_limit(7'd1);
    send_item(ActSchedule, 64'd3, '0, '0, 32'd1);
    send_item(ActSchedule, 64'd4, '0, '0, 32'd2);
    write_limit(7'd0);
    send_item(ActSchedule, 64'd4, '0, '0, 32'd3);
    write_limit(7'd127);
    send_item(ActSchedule, 64'd9, '0, '0, 32'd4);
    send_item(ActSchedule, 64'd2, '0, '0, 32'd5);
    write_limit(7'd1);
    send_item(ActPeek, '0, '0, '0, '0);
    send_item(ActTakeNewest, '0, '0, '0, '0);
  endtask

  task automatic test_unused_actions();
    send_item(3'd5, '0, '0, '0, '0);
    send_item(3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_traffic();
    logic [6:0] limits [6];
    limits = '{7'd64, 7'd2, 7'd8, 7'd127, 7'd1, 7'd64};
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 300 == 0) write_limit(n / 300 < 6 ? limits[n / 300] : 7'($urandom()));
      if (n == 800) drain_results();
      if (n == RandomItems - 200) quiet = 1'b1;
      if (n % 150 == 100 && n < 1400) begin
        repeat ($urandom_range(20, 70)) begin
          send_item(ActSchedule, pick_deadline(), '0, '0, $urandom());
          n++;
        end
      end
      random_item();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_schedule_and_peek();
    test_take_ready();
    test_take_by_id();
    test_capacity_limits();
    test_unused_actions();
    test_random_traffic();
    drain_results();
    repeat (200) @(posedge clk);
    $display("Sent %0d items, checked %0d results, %0d limit writes.", items_sent,
             resp_checked, limit_writes);
    $display("Saw %0d full reports and %0d successful removals.", full_seen, ok_takes);
    if (errors == 0 && pending_resp.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

@@ deadline_timer_queue.f @@
+incdir+src
src/dtq_pkg.sv
src/dtq_ram.sv
src/deadline_timer_queue.sv
tb/deadline_timer_queue_test.sv
